// ----- hw/rtl/i2r_pkg.sv -----
package i2r_pkg;

  localparam int unsigned DIGITS = 4;

  localparam logic [6:0] CH_NONE = 7'h00;
  localparam logic [6:0] CH_I    = 7'h49;
  localparam logic [6:0] CH_V    = 7'h56;
  localparam logic [6:0] CH_X    = 7'h58;
  localparam logic [6:0] CH_L    = 7'h4C;
  localparam logic [6:0] CH_C    = 7'h43;
  localparam logic [6:0] CH_D    = 7'h44;
  localparam logic [6:0] CH_M    = 7'h4D;

  localparam logic [11:0] TOP_VALID = 12'd3999;

  // Digit slot 0 holds thousands, slot 3 holds ones.
  typedef struct packed {
    logic                   err;
    logic [DIGITS-1:0][3:0] d;
  } entry_t;

  typedef struct packed {
    logic       found;
    logic [1:0] pos;
  } nz_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam logic [DIGITS-1:0][6:0] ONE_CH  = {CH_I, CH_X, CH_C, CH_M};
  localparam logic [DIGITS-1:0][6:0] FIVE_CH = {CH_V, CH_L, CH_D, CH_NONE};
  localparam logic [DIGITS-1:0][6:0] TEN_CH  = {CH_X, CH_C, CH_M, CH_NONE};

  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] letter_of(input logic [1:0] pos, input logic [3:0] d,
                                           input logic [1:0] step);
    logic [6:0] ch;
    priority if (d == 4'd9) begin
      ch = (step == 2'd0) ? ONE_CH[pos] : TEN_CH[pos];
    end else if (d == 4'd4) begin
      ch = (step == 2'd0) ? ONE_CH[pos] : FIVE_CH[pos];
    end else if (d >= 4'd5 && step == 2'd0) begin
      ch = FIVE_CH[pos];
    end else begin
      ch = ONE_CH[pos];
    end
    return ch;
  endfunction

  // First nonzero digit at or after slot start; start may be one past the end.
  function automatic nz_t find_nz(input logic [DIGITS-1:0][3:0] d, input logic [2:0] start);
    nz_t r;
    r = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (!r.found && 3'(i) >= start && d[i] != 4'd0) begin
        r.found = 1'b1;
        r.pos   = 2'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/i2r_front.sv -----
module i2r_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [15:0]     s_tdata,
  output logic            push,
  output i2r_pkg::entry_t push_entry,
  input  logic            q_full
);
  import i2r_pkg::*;

  logic        a_valid;
  logic        a_err;
  logic [1:0]  a_th;
  logic [9:0]  a_rem;

  logic [11:0] v;
  logic        v_err;
  logic [1:0]  th;
  logic [11:0] th_sub;
  logic [3:0]  h;
  logic [9:0]  h_sub;
  logic [6:0]  r2;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  assign v        = s_tdata[11:0];
  assign push     = a_valid && !q_full;
  assign s_tready = !a_valid || !q_full;

  // Stage A: range check and thousands digit.
  always_comb begin
    v_err = (v == 12'd0) || (v > TOP_VALID);
    priority if (v >= 12'd3000) begin
      th = 2'd3;
    end else if (v >= 12'd2000) begin
      th = 2'd2;
    end else if (v >= 12'd1000) begin
      th = 2'd1;
    end else begin
      th = 2'd0;
    end
    unique case (th)
      2'd0:    th_sub = 12'd0;
      2'd1:    th_sub = 12'd1000;
      2'd2:    th_sub = 12'd2000;
      2'd3:    th_sub = 12'd3000;
      default: th_sub = 12'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_err <= v_err;
      a_th  <= th;
      a_rem <= 10'(v - th_sub);
    end
  end

  // Stage B: hundreds by compare, then tens and ones of the rest.
  always_comb begin
    priority if (a_rem >= 10'd900) begin
      h = 4'd9;
    end else if (a_rem >= 10'd800) begin
      h = 4'd8;
    end else if (a_rem >= 10'd700) begin
      h = 4'd7;
    end else if (a_rem >= 10'd600) begin
      h = 4'd6;
    end else if (a_rem >= 10'd500) begin
      h = 4'd5;
    end else if (a_rem >= 10'd400) begin
      h = 4'd4;
    end else if (a_rem >= 10'd300) begin
      h = 4'd3;
    end else if (a_rem >= 10'd200) begin
      h = 4'd2;
    end else if (a_rem >= 10'd100) begin
      h = 4'd1;
    end else begin
      h = 4'd0;
    end
    h_sub     = 10'({6'd0, h} * 10'd100);
    r2        = 7'(a_rem - h_sub);
    // x * 205 >> 11 equals x / 10 for every x below 100.
    tens_prod = {8'd0, r2} * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(r2 - 7'({3'd0, tens} * 7'd10));
  end

  always_comb begin
    push_entry.err  = a_err;
    push_entry.d[0] = {2'd0, a_th};
    push_entry.d[1] = h;
    push_entry.d[2] = tens;
    push_entry.d[3] = ones;
  end

endmodule

// ----- hw/rtl/i2r_queue.sv -----
module i2r_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  i2r_pkg::entry_t push_entry,
  output logic            full,
  output logic            valid,
  output i2r_pkg::entry_t head,
  input  logic            pop
);
  import i2r_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/i2r_back.sv -----
module i2r_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  i2r_pkg::entry_t q_head,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast,
  output logic            m_tuser
);
  import i2r_pkg::*;

  state_t     state;
  state_t     state_next;
  entry_t     cur;
  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [1:0] step;
  logic [1:0] step_next;
  logic       take_head;

  entry_t     src;
  nz_t        first;
  nz_t        nxt;
  logic [1:0] pos_sel;
  logic [1:0] step_sel;
  logic [3:0] dig;
  logic       end_digit;
  logic       out_free;
  logic       emit;
  logic [6:0] ch;
  logic       is_last;
  logic       is_err;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    src       = (state == ST_IDLE) ? q_head : cur;
    first     = find_nz(src.d, 3'd0);
    pos_sel   = (state == ST_IDLE) ? first.pos : pos;
    step_sel  = (state == ST_IDLE) ? 2'd0 : step;
    dig       = src.d[pos_sel];
    end_digit = ({1'b0, step_sel} + 3'd1) == digit_len(dig);
    nxt       = find_nz(src.d, {1'b0, pos_sel} + 3'd1);
    is_err    = (state == ST_IDLE) && q_head.err;
    ch        = is_err ? CH_NONE : letter_of(pos_sel, dig, step_sel);
    is_last   = is_err || (end_digit && !nxt.found);
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    step_next  = step;
    pop        = 1'b0;
    emit       = 1'b0;
    take_head  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          pop  = 1'b1;
          emit = 1'b1;
          if (!is_last) begin
            take_head  = 1'b1;
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          emit = 1'b1;
          if (is_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (emit && !is_last) begin
      if (end_digit) begin
        pos_next  = nxt.pos;
        step_next = 2'd0;
      end else begin
        pos_next  = pos_sel;
        step_next = step_sel + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    step <= step_next;
    if (take_head) begin
      cur <= q_head;
    end
    if (emit) begin
      m_tdata <= {1'b0, ch};
      m_tlast <= is_last;
      m_tuser <= is_err;
    end
  end

endmodule

// ----- hw/rtl/integer_to_roman_numeral_core.sv -----
// Channel   Dir  tdata                     tlast           tuser
// s_*       in   [11:0] value, [15:12] 0   -               -
// m_*       out  [6:0] char_code, [7] 0    last letter     error
//
// In the front an item gets its thousands digit, then hundreds/tens/ones, and
// waits in a small queue; the back sequencer then sends one letter per cycle
// while the result side accepts. An item has 1 to 15 letters, and items
// follow each other with no gap; the letter sequencer sets the rate.
// Reset is synchronous and clears valid flags, queue pointers and the
// sequencer state. A stall on the result side fills the queue and then
// drops s_tready; the front and back stall independently.
module integer_to_roman_numeral_core #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [15:0] s_tdata,  // [11:0] value
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] char_code
  output logic       m_tlast,
  output logic       m_tuser    // [0] error
);
  import i2r_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_head;
  logic   pop;

  i2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full)
  );

  i2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (pop)
  );

  i2r_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- hw/rtl/i2r_checker.sv -----
module i2r_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [15:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic       m_tuser
);
  import i2r_pkg::*;

  logic s_seen;
  assign s_seen = s_tvalid && s_tready && (s_tdata != 16'd0);

  // A stalled letter stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result item changed while stalled");

  // An out-of-range item is a single marked item with no letter.
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
    else $error("error item malformed");

  // Every normal item carries a numeral letter.
  a_letter: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == {1'b0, CH_I} || m_tdata == {1'b0, CH_V}
      || m_tdata == {1'b0, CH_X} || m_tdata == {1'b0, CH_L} || m_tdata == {1'b0, CH_C}
      || m_tdata == {1'b0, CH_D} || m_tdata == {1'b0, CH_M})
    else $error("result item is not a numeral letter");

  // Results cannot appear right after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // An item that enters right after reset passes the front register and the queue before it reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !m_tvalid && s_seen |=> !m_tvalid)
    else $error("result appeared too early after reset");

endmodule

bind integer_to_roman_numeral_core i2r_checker u_i2r_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ----- bench/roman_stream_checker.sv -----
module roman_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [6:0] char_code
  input  logic        m_tlast,
  input  logic        m_tuser,   // [0] error
  output int          errors,
  output int          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import i2r_pkg::*;

  typedef struct packed {
    logic [6:0] code;
    logic       is_last;
    logic       err;
  } letter_t;

  letter_t letters_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic add_letter(input logic [6:0] code);
    letters_due.push_back(letter_t'{code, 1'b0, 1'b0});
  endtask

  // One decimal digit in the subtractive form, from its unit, five and ten letters.
  task automatic add_digit(input int unsigned d, input logic [6:0] one,
                           input logic [6:0] five, input logic [6:0] ten);
    if (d == 9) begin
      add_letter(one);
      add_letter(ten);
    end else if (d == 4) begin
      add_letter(one);
      add_letter(five);
    end else begin
      if (d >= 5) begin
        add_letter(five);
        d -= 5;
      end
      for (int k = 0; k < d; k++) add_letter(one);
    end
  endtask

  task automatic expand_numeral(input logic [11:0] value);
    int unsigned n;
    letter_t     tail;
    n = value;
    if (n == 0 || value > TOP_VALID) begin
      letters_due.push_back(letter_t'{CH_NONE, 1'b1, 1'b1});
    end else begin
      for (int k = 0; k < n / 1000; k++) add_letter(CH_M);
      add_digit((n / 100) % 10, CH_C, CH_D, CH_M);
      add_digit((n / 10) % 10, CH_X, CH_L, CH_C);
      add_digit(n % 10, CH_I, CH_V, CH_X);
      tail = letters_due.pop_back();
      tail.is_last = 1'b1;
      letters_due.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    letter_t want;
    letter_t got;
    if (rst) begin
      letters_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = letter_t'{m_tdata[6:0], m_tlast, m_tuser};
        if (letters_due.size() == 0) begin
          $display("%0t: unexpected letter code=%h last=%b err=%b",
                   $time, got.code, got.is_last, got.err);
          errors++;
        end else begin
          want = letters_due.pop_front();
          if (got.code !== want.code || got.is_last !== want.is_last ||
              got.err !== want.err) begin
            $display("%0t: mismatch expected code=%h last=%b err=%b, got code=%h last=%b err=%b",
                     $time, want.code, want.is_last, want.err,
                     got.code, got.is_last, got.err);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) expand_numeral(s_tdata[11:0]);
    end
    pending = letters_due.size();
  end

endmodule

// ----- bench/integer_to_roman_numeral_core_tb.sv -----
module integer_to_roman_numeral_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 430;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [11:0] value
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [6:0] char_code
  logic        m_tlast;
  logic        m_tuser;   // [0] error

  int errors;
  int pending;
  int cycle_count;
  int sender_gap_pct;
  int sink_stall_pct;

  logic [11:0] corner_values[$] = '{
    12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10, 12'd14, 12'd40,
    12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd900, 12'd999, 12'd1000,
    12'd1994, 12'd2048, 12'd3888, 12'd3999, 12'd4000, 12'd4095, 12'd2222
  };

  integer_to_roman_numeral_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  roman_stream_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    m_tready    = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Entered and left at a falling edge; valid stays high into the next item.
  task automatic send_value(input logic [11:0] value);
    while ($urandom_range(99) < sender_gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0, value};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic logic [11:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 12'd0;
    if (r < 14) return 12'($urandom_range(4095, 4000));
    // Digit by digit, so long numerals and every subtractive form turn up often.
    if (r < 60) begin
      return 12'($urandom_range(3) * 1000 + $urandom_range(9) * 100 +
                 $urandom_range(9) * 10 + $urandom_range(9));
    end
    return 12'($urandom_range(3999, 1));
  endfunction

  task automatic set_phase(input int phase);
    case (phase)
      1: begin
        sender_gap_pct = 75;
        sink_stall_pct = 0;
      end
      2: begin
        sender_gap_pct = 0;
        sink_stall_pct = 75;
      end
      3: begin
        sender_gap_pct = 17;
        sink_stall_pct = 17;
      end
      default: begin
        sender_gap_pct = 0;
        sink_stall_pct = 0;
      end
    endcase
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    set_phase(0);
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (corner_values[i]) send_value(corner_values[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % (RANDOM_ITEMS / 5) == 0) set_phase((i / (RANDOM_ITEMS / 5)) % 4);
      send_value(pick_value());
    end
    s_tvalid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- integer_to_roman_numeral_core.f -----
hw/rtl/i2r_pkg.sv
hw/rtl/i2r_front.sv
hw/rtl/i2r_queue.sv
hw/rtl/i2r_back.sv
hw/rtl/integer_to_roman_numeral_core.sv
hw/rtl/i2r_checker.sv
bench/roman_stream_checker.sv
bench/integer_to_roman_numeral_core_tb.sv
